// ===== design/pvm_pkg.sv =====
// Shared types, codes and constant tables for the PCM voice mixer.
`timescale 1ns / 1ps
package pvm_pkg;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] reg_addr;
      logic [15:0] write_data;
      logic [15:0] rom_addr;
      logic [7:0]  rom_byte;
   } req_item_type;

   typedef struct packed {
      logic               result_kind;
      logic [15:0]        read_data;
      logic signed [15:0] out_left1;
      logic signed [15:0] out_right1;
      logic signed [15:0] out_left2;
      logic signed [15:0] out_right2;
   } rsp_item_type;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;
   localparam logic [1:0] CMD_LOAD  = 2'd3;

   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_FRAME = 1'b1;

   typedef struct packed {
      logic [1:0]  kind;
      logic        voice_ok;
      logic [11:0] voice;
      logic [3:0]  offset;
      logic [15:0] data;
      logic [15:0] rom_addr;
      logic [7:0]  rom_byte;
   } cmd_type;

   localparam logic [3:0] OFS_VOL1  = 4'h0;
   localparam logic [3:0] OFS_VOL2  = 4'h2;
   localparam logic [3:0] OFS_PITCH = 4'h4;
   localparam logic [3:0] OFS_FLAGS = 4'h6;
   localparam logic [3:0] OFS_BANK  = 4'h8;
   localparam logic [3:0] OFS_START = 4'ha;
   localparam logic [3:0] OFS_END   = 4'hc;
   localparam logic [3:0] OFS_LOOP  = 4'he;

   localparam int FLAG_REVERSE = 0;
   localparam int FLAG_LOOP    = 1;
   localparam int FLAG_MULAW   = 3;
   localparam int FLAG_NOISE   = 4;
   localparam int FLAG_LONG    = 5;
   localparam int FLAG_PHASE   = 7;
   localparam int FLAG_ACTIVE  = 14;
   localparam int FLAG_FIXED   = 16;

   localparam logic [31:0] NOISE_SEED = 32'h1234_5678;
   localparam logic [15:0] SCALE_RESET = 16'd256;

   typedef logic signed [15:0] mulaw_table_type [256];
   typedef logic [7:0] level_table_type [256];

   function automatic mulaw_table_type build_mulaw();
      mulaw_table_type t;
      real ln9;
      real x;
      integer m;
      integer mag;
      integer i;
      ln9 = $ln(9.0);
      for (i = 0; i < 256; i++) begin
         m = i & 127;
         if (m == 0) begin
            mag = 0;
         end else if (m == 127) begin
            mag = 25000;
         end else begin
            x = m * ln9 / 127.0;
            mag = $rtoi($floor(($exp(x) - 1.0) * 3125.0));
         end
         t[i] = (i >= 128) ? -16'(mag) : 16'(mag);
      end
      return t;
   endfunction

   function automatic level_table_type build_level();
      level_table_type t;
      real x;
      integer j;
      for (j = 0; j < 255; j++) begin
         x = (j + 1) / 256.0;
         t[j] = 8'($rtoi($floor(25.5 * $pow(10.0, x))));
      end
      t[255] = 8'd255;
      return t;
   endfunction

   localparam mulaw_table_type MULAW_TABLE = build_mulaw();
   localparam level_table_type LEVEL_TABLE = build_level();

endpackage

// ===== design/pvm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pvm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/pvm_front.sv =====
// Front end: accepts items, classifies them and queues commands.
`timescale 1ns / 1ps
module pvm_front #(
   parameter int VOICES = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  pvm_pkg::req_item_type req_item,
   output logic                  cmd_valid,
   output pvm_pkg::cmd_type      cmd,
   input  logic                  cmd_take
);

   pvm_pkg::cmd_type q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   pvm_pkg::cmd_type new_cmd;
   logic             accept;
   logic             take;

   always_comb begin
      new_cmd.kind     = req_item.mode;
      new_cmd.voice    = req_item.reg_addr[15:4];
      new_cmd.voice_ok = (32'(req_item.reg_addr[15:4]) < 32'(VOICES));
      new_cmd.offset   = req_item.reg_addr[3:0];
      new_cmd.data     = req_item.write_data;
      new_cmd.rom_addr = req_item.rom_addr;
      new_cmd.rom_byte = req_item.rom_byte;
   end

   assign full      = (count_ff == 2'd2);
   assign accept    = push && !full;
   assign cmd_valid = (count_ff != 2'd0);
   assign take      = cmd_take && cmd_valid;
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, accept} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ===== design/pvm_back.sv =====
// Back end: voice registers, voice start fix-up, per-tick voice walk and mixing.
`timescale 1ns / 1ps
module pvm_back #(
   parameter int VOICES        = 32,
   parameter int ROM_ADDR_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [15:0]              csr_wdata,
   input  logic                     cmd_valid,
   input  pvm_pkg::cmd_type         cmd,
   output logic                     cmd_take,
   output logic                     rom_we,
   output logic [ROM_ADDR_BITS-1:0] rom_waddr,
   output logic [7:0]               rom_wdata,
   output logic [ROM_ADDR_BITS-1:0] rom_raddr,
   input  logic [7:0]               rom_rdata,
   output pvm_pkg::rsp_item_type    rsp_item,
   output logic                     empty,
   input  logic                     pop
);

   localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam logic [31:0] POS_MASK = 32'((64'd1 << ROM_ADDR_BITS) - 64'd1);
   localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(VOICES - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FIX   = 3'd1;
   localparam logic [2:0] ST_PREP  = 3'd2;
   localparam logic [2:0] ST_OFF   = 3'd3;
   localparam logic [2:0] ST_POS   = 3'd4;
   localparam logic [2:0] ST_FETCH = 3'd5;
   localparam logic [2:0] ST_MIX   = 3'd6;

   logic [31:0] voice_volumes_ff  [VOICES];
   logic [15:0] voice_pitch_ff    [VOICES];
   logic [7:0]  voice_bank_ff     [VOICES];
   logic [15:0] voice_start_ff    [VOICES];
   logic [15:0] voice_end_ff      [VOICES];
   logic [16:0] voice_flags_ff    [VOICES];
   logic [31:0] voice_position_ff [VOICES];
   logic [31:0] voice_stop_ff     [VOICES];
   logic [31:0] voice_loop_ff     [VOICES];
   logic [31:0] voice_fraction_ff [VOICES];
   logic [15:0] voice_noise_ff    [VOICES];

   logic [31:0] voice_volumes_in, voice_position_in, voice_stop_in;
   logic [31:0] voice_loop_in, voice_fraction_in;
   logic [15:0] voice_pitch_in, voice_start_in, voice_end_in, voice_noise_in;
   logic [7:0]  voice_bank_in;
   logic [16:0] voice_flags_in;
   logic we_vol, we_pitch, we_bank, we_start, we_end, we_flags;
   logic we_pos, we_stop, we_loop, we_frac, we_noise;

   logic [2:0]         state_ff, state_in;
   logic [VIDX_W-1:0]  cur_ff, cur_in;
   logic [31:0]        fstop_ff, fstop_in;
   logic               flt_ff, flt_in, fgt_ff, fgt_in;
   logic [31:0]        mult_ff, mult_in;
   logic [31:0]        off_ff, off_in;
   logic [14:0]        cnt_ff, cnt_in;
   logic [31:0]        ptmp_ff, ptmp_in;
   logic signed [15:0] s_ff, s_in;
   logic [31:0]        lfsr_ff, lfsr_in;
   logic signed [23:0] acc_ff [4];
   logic signed [23:0] acc_in [4];
   logic [15:0]        scale_ff, scale_in;
   logic               out_valid_ff, out_valid_in;
   pvm_pkg::rsp_item_type out_item_ff, out_item_in;

   logic [VIDX_W-1:0] vsel;
   logic [31:0] vol, pos, stop, loopv, frac;
   logic [15:0] pitch, startv, endv, noise;
   logic [7:0]  bank;
   logic [16:0] flags;

   logic [31:0] rom_ext;
   logic [23:0] new_pos24, new_stop24;
   logic [31:0] offs, p, p2, bank_hi, stop_adj, loop_adj;
   logic        hit, dec_stop, dec_loop;
   logic [8:0]  bank_inc;
   logic [7:0]  byte_v, t_idx;
   logic [15:0] n_val;
   logic [31:0] lfsr_next;
   logic signed [15:0] s_val;
   logic signed [24:0] prod;
   logic        advance;

   assign vsel = (state_ff == ST_IDLE) ? cmd.voice[VIDX_W-1:0] : cur_ff;
   assign vol    = voice_volumes_ff[vsel];
   assign pitch  = voice_pitch_ff[vsel];
   assign bank   = voice_bank_ff[vsel];
   assign startv = voice_start_ff[vsel];
   assign endv   = voice_end_ff[vsel];
   assign flags  = voice_flags_ff[vsel];
   assign pos    = voice_position_ff[vsel];
   assign stop   = voice_stop_ff[vsel];
   assign loopv  = voice_loop_ff[vsel];
   assign frac   = voice_fraction_ff[vsel];
   assign noise  = voice_noise_ff[vsel];

   assign rom_ext   = {16'd0, cmd.rom_addr};
   assign rom_waddr = rom_ext[ROM_ADDR_BITS-1:0];
   assign rom_wdata = cmd.rom_byte;
   assign empty     = !out_valid_ff;
   assign rsp_item  = out_item_ff;

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      fstop_in = fstop_ff;
      flt_in = flt_ff;
      fgt_in = fgt_ff;
      mult_in = mult_ff;
      off_in = off_ff;
      cnt_in = cnt_ff;
      ptmp_in = ptmp_ff;
      s_in = s_ff;
      lfsr_in = lfsr_ff;
      for (int k = 0; k < 4; k++) begin
         acc_in[k] = acc_ff[k];
      end
      scale_in = csr_we ? csr_wdata : scale_ff;
      out_valid_in = out_valid_ff && !pop;
      out_item_in = out_item_ff;

      voice_volumes_in = vol;
      voice_pitch_in = pitch;
      voice_bank_in = bank;
      voice_start_in = startv;
      voice_end_in = endv;
      voice_flags_in = flags;
      voice_position_in = pos;
      voice_stop_in = stop;
      voice_loop_in = loopv;
      voice_fraction_in = frac;
      voice_noise_in = noise;
      {we_vol, we_pitch, we_bank, we_start, we_end, we_flags} = '0;
      {we_pos, we_stop, we_loop, we_frac, we_noise} = '0;

      cmd_take = 1'b0;
      rom_we = 1'b0;
      advance = 1'b0;

      new_pos24 = {bank, startv};
      new_stop24 = {bank, endv};
      offs = frac + {8'd0, mult_ff[31:8]};
      p = flags[pvm_pkg::FLAG_REVERSE] ? pos - {17'd0, cnt_ff} : pos + {17'd0, cnt_ff};
      hit = flags[pvm_pkg::FLAG_REVERSE] ? (p <= loopv) : (p >= stop);
      p2 = p;
      if (hit) begin
         p2 = flags[pvm_pkg::FLAG_REVERSE] ? stop : loopv;
      end
      rom_raddr = p2[ROM_ADDR_BITS-1:0];

      bank_hi = {8'd0, bank, 16'd0};
      dec_stop = flt_ff && (fstop_ff >= 32'h0001_0000);
      dec_loop = flt_ff && (loopv >= 32'h0001_0000);
      bank_inc = {1'b0, bank} + {8'd0, fgt_ff};
      if (flags[pvm_pkg::FLAG_REVERSE]) begin
         stop_adj = fstop_ff - {15'd0, dec_stop, 16'd0};
         loop_adj = loopv + (bank_hi - {15'd0, dec_loop, 16'd0});
      end else begin
         stop_adj = fstop_ff + {15'd0, fgt_ff, 16'd0};
         loop_adj = loopv + {7'd0, bank_inc, 16'd0};
      end

      byte_v = rom_rdata;
      lfsr_next = lfsr_ff[16] ? {lfsr_ff[30:0] ^ 31'h40, 1'b1} : {lfsr_ff[30:0], 1'b0};
      n_val = {noise[14:0], lfsr_next[0]};
      if (!n_val[14]) begin
         t_idx = 8'd0;
      end else if (n_val[13:8] != 6'd0) begin
         t_idx = 8'hff;
      end else begin
         t_idx = n_val[7:0];
      end
      s_val = flags[pvm_pkg::FLAG_MULAW] ? pvm_pkg::MULAW_TABLE[byte_v] : {byte_v, 8'd0};
      if (flags[pvm_pkg::FLAG_PHASE]) begin
         s_val = -s_val;
      end
      if (flags[pvm_pkg::FLAG_NOISE]) begin
         s_val = pvm_pkg::MULAW_TABLE[t_idx];
      end
      prod = '0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !out_valid_ff) begin
               cmd_take = 1'b1;
               case (cmd.kind)
                  pvm_pkg::CMD_WRITE: begin
                     if (cmd.voice_ok) begin
                        case (cmd.offset)
                           pvm_pkg::OFS_VOL1: begin
                              voice_volumes_in = {vol[31:16], cmd.data};
                              we_vol = 1'b1;
                           end
                           pvm_pkg::OFS_VOL2: begin
                              voice_volumes_in = {cmd.data, vol[15:0]};
                              we_vol = 1'b1;
                           end
                           pvm_pkg::OFS_PITCH: begin
                              voice_pitch_in = cmd.data;
                              we_pitch = 1'b1;
                           end
                           pvm_pkg::OFS_FLAGS: begin
                              voice_flags_in = {flags[pvm_pkg::FLAG_FIXED], cmd.data};
                              we_flags = 1'b1;
                              if (cmd.data[pvm_pkg::FLAG_ACTIVE]) begin
                                 voice_position_in = {8'd0, new_pos24};
                                 we_pos = 1'b1;
                                 fstop_in = {8'd0, new_stop24};
                                 flt_in = new_pos24 < new_stop24;
                                 fgt_in = new_pos24 > new_stop24;
                                 cur_in = vsel;
                                 state_in = ST_FIX;
                              end
                           end
                           pvm_pkg::OFS_BANK: begin
                              voice_bank_in = cmd.data[7:0];
                              we_bank = 1'b1;
                           end
                           pvm_pkg::OFS_START: begin
                              voice_flags_in = {1'b0, flags[15:0]};
                              voice_start_in = cmd.data;
                              we_flags = 1'b1;
                              we_start = 1'b1;
                           end
                           pvm_pkg::OFS_END: begin
                              voice_flags_in = {1'b0, flags[15:0]};
                              voice_end_in = cmd.data;
                              we_flags = 1'b1;
                              we_end = 1'b1;
                           end
                           pvm_pkg::OFS_LOOP: begin
                              voice_flags_in = {1'b0, flags[15:0]};
                              voice_loop_in = {16'd0, cmd.data};
                              we_flags = 1'b1;
                              we_loop = 1'b1;
                           end
                           default: begin
                           end
                        endcase
                     end
                  end
                  pvm_pkg::CMD_READ: begin
                     out_valid_in = 1'b1;
                     out_item_in = '0;
                     out_item_in.result_kind = pvm_pkg::KIND_READ;
                     out_item_in.read_data = cmd.voice_ok ? flags[15:0] : 16'd0;
                  end
                  pvm_pkg::CMD_TICK: begin
                     cur_in = '0;
                     for (int k = 0; k < 4; k++) begin
                        acc_in[k] = '0;
                     end
                     state_in = ST_PREP;
                  end
                  pvm_pkg::CMD_LOAD: begin
                     rom_we = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FIX: begin
            voice_stop_in = fstop_ff;
            voice_fraction_in = '0;
            we_stop = 1'b1;
            we_frac = 1'b1;
            if (!flags[pvm_pkg::FLAG_FIXED]) begin
               voice_stop_in = stop_adj;
               voice_loop_in = loop_adj;
               we_loop = 1'b1;
               voice_flags_in = flags;
               voice_flags_in[pvm_pkg::FLAG_FIXED] = 1'b1;
               if (flags[pvm_pkg::FLAG_LONG] ||
                   (!flags[pvm_pkg::FLAG_REVERSE] && (loop_adj > stop_adj))) begin
                  voice_flags_in[pvm_pkg::FLAG_LOOP] = 1'b0;
               end
               we_flags = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_PREP: begin
            if (!flags[pvm_pkg::FLAG_ACTIVE]) begin
               advance = 1'b1;
            end else begin
               mult_in = pitch * scale_ff;
               state_in = ST_OFF;
            end
         end
         ST_OFF: begin
            cnt_in = offs[30:16];
            off_in = (offs[30:16] != 15'd0) ? {16'd0, offs[15:0]} : offs;
            state_in = ST_POS;
         end
         ST_POS: begin
            if (hit && !flags[pvm_pkg::FLAG_LOOP]) begin
               voice_flags_in = flags;
               voice_flags_in[pvm_pkg::FLAG_ACTIVE] = 1'b0;
               we_flags = 1'b1;
               advance = 1'b1;
            end else begin
               ptmp_in = p2 & POS_MASK;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            s_in = s_val;
            if (flags[pvm_pkg::FLAG_NOISE]) begin
               lfsr_in = lfsr_next;
               voice_noise_in = n_val;
               we_noise = 1'b1;
            end
            state_in = ST_MIX;
         end
         ST_MIX: begin
            for (int k = 0; k < 4; k++) begin
               prod = s_ff * $signed({1'b0, pvm_pkg::LEVEL_TABLE[vol[8*k +: 8]]});
               acc_in[k] = acc_ff[k] + 24'(prod >>> 8);
            end
            voice_fraction_in = off_ff;
            voice_position_in = ptmp_ff;
            we_frac = 1'b1;
            we_pos = 1'b1;
            advance = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (advance) begin
         if (cur_ff == LAST_VOICE) begin
            out_valid_in = 1'b1;
            out_item_in.result_kind = pvm_pkg::KIND_FRAME;
            out_item_in.read_data = 16'd0;
            out_item_in.out_left1 = $signed(acc_in[0][18:3]);
            out_item_in.out_right1 = $signed(acc_in[1][18:3]);
            out_item_in.out_left2 = $signed(acc_in[2][18:3]);
            out_item_in.out_right2 = $signed(acc_in[3][18:3]);
            state_in = ST_IDLE;
         end else begin
            cur_in = cur_ff + 1'b1;
            state_in = ST_PREP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cur_ff <= '0;
         lfsr_ff <= pvm_pkg::NOISE_SEED;
         scale_ff <= pvm_pkg::SCALE_RESET;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < VOICES; i++) begin
            voice_volumes_ff[i] <= '0;
            voice_pitch_ff[i] <= '0;
            voice_bank_ff[i] <= '0;
            voice_start_ff[i] <= '0;
            voice_end_ff[i] <= '0;
            voice_flags_ff[i] <= '0;
            voice_position_ff[i] <= '0;
            voice_stop_ff[i] <= '0;
            voice_loop_ff[i] <= '0;
            voice_fraction_ff[i] <= '0;
            voice_noise_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         cur_ff <= cur_in;
         lfsr_ff <= lfsr_in;
         scale_ff <= scale_in;
         out_valid_ff <= out_valid_in;
         if (we_vol)   voice_volumes_ff[vsel] <= voice_volumes_in;
         if (we_pitch) voice_pitch_ff[vsel] <= voice_pitch_in;
         if (we_bank)  voice_bank_ff[vsel] <= voice_bank_in;
         if (we_start) voice_start_ff[vsel] <= voice_start_in;
         if (we_end)   voice_end_ff[vsel] <= voice_end_in;
         if (we_flags) voice_flags_ff[vsel] <= voice_flags_in;
         if (we_pos)   voice_position_ff[vsel] <= voice_position_in;
         if (we_stop)  voice_stop_ff[vsel] <= voice_stop_in;
         if (we_loop)  voice_loop_ff[vsel] <= voice_loop_in;
         if (we_frac)  voice_fraction_ff[vsel] <= voice_fraction_in;
         if (we_noise) voice_noise_ff[vsel] <= voice_noise_in;
      end
   end

   always_ff @(posedge clock) begin
      fstop_ff <= fstop_in;
      flt_ff <= flt_in;
      fgt_ff <= fgt_in;
      mult_ff <= mult_in;
      off_ff <= off_in;
      cnt_ff <= cnt_in;
      ptmp_ff <= ptmp_in;
      s_ff <= s_in;
      out_item_ff <= out_item_in;
      for (int k = 0; k < 4; k++) begin
         acc_ff[k] <= acc_in[k];
      end
   end

endmodule

// ===== design/pcm_voice_mixer_32ch.sv =====
// Top level of the 32-voice PCM sample player and mixer.
//
// Input queue: an item (register write, flag read, output tick or sample ROM
// byte load) is taken when push is high and full is low. A two-entry command
// queue sits behind it, so items are taken while a result waits.
// Result slot: the one pending result shows on rsp_item while empty is low and
// leaves when pop is high. Flag reads give one result, ticks one audio frame,
// writes and loads none.
// In the back end a write or load completes when it is taken; a flag write that starts a
// voice passes through a fix-up state as well. A read result is registered when taken.
// A tick walks the voices in order: an idle voice is only looked at, an active one goes
// through multiply, offset add, position step, ROM read and mix.
// The back end starts a command only while the result slot is free, so a
// stalled receiver holds the back end and then fills the input queue.
// Reset clears all voice registers, sets the noise register to its seed and
// pitch_scale to 256; the sample ROM holds no defined data until loaded.
// csr_we writes pitch_scale; write it only while the block is idle.
`timescale 1ns / 1ps
module pcm_voice_mixer_32ch #(
   parameter int VOICES        = 32,
   parameter int ROM_ADDR_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  pvm_pkg::req_item_type req_item,
   output logic                  empty,
   input  logic                  pop,
   output pvm_pkg::rsp_item_type rsp_item,
   input  logic                  csr_we,
   input  logic [15:0]           csr_wdata
);

   logic                     cmd_valid;
   logic                     cmd_take;
   pvm_pkg::cmd_type         cmd;
   logic                     rom_we;
   logic [ROM_ADDR_BITS-1:0] rom_waddr;
   logic [7:0]               rom_wdata;
   logic [ROM_ADDR_BITS-1:0] rom_raddr;
   logic [7:0]               rom_rdata;

   pvm_front #(
      .VOICES(VOICES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .cmd_valid(cmd_valid),
      .cmd      (cmd),
      .cmd_take (cmd_take)
   );

   pvm_ram #(
      .WIDTH(8),
      .DEPTH(1 << ROM_ADDR_BITS)
   ) u_rom (
      .clock(clock),
      .we   (rom_we),
      .waddr(rom_waddr),
      .wdata(rom_wdata),
      .raddr(rom_raddr),
      .rdata(rom_rdata)
   );

   pvm_back #(
      .VOICES       (VOICES),
      .ROM_ADDR_BITS(ROM_ADDR_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .cmd_valid(cmd_valid),
      .cmd      (cmd),
      .cmd_take (cmd_take),
      .rom_we   (rom_we),
      .rom_waddr(rom_waddr),
      .rom_wdata(rom_wdata),
      .rom_raddr(rom_raddr),
      .rom_rdata(rom_rdata),
      .rsp_item (rsp_item),
      .empty    (empty),
      .pop      (pop)
   );

endmodule

// ===== verif/pvm_mix_checker.sv =====
// Checker for the PCM voice mixer: predicts each result from the accepted items and compares.
`timescale 1ns / 1ps
module pvm_mix_checker
   import pvm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic         full,
   input  req_item_type req_item,
   input  logic         empty,
   input  logic         pop,
   input  rsp_item_type rsp_item,
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata,
   output int           mismatches,
   output int           pending
);

   localparam bit [63:0] ONE_FX = 64'd1 << 60;

   logic [31:0]        vol    [32];
   logic [15:0]        pitch  [32];
   logic [7:0]         bank   [32];
   logic [15:0]        vstart [32];
   logic [15:0]        vend   [32];
   logic [16:0]        flags  [32];
   logic [31:0]        pos    [32];
   logic [31:0]        vstop  [32];
   logic [31:0]        vloop  [32];
   logic [31:0]        frac   [32];
   logic [15:0]        noise  [32];
   logic [31:0]        lfsr;
   logic [15:0]        scale;
   logic [7:0]         rom    [65536];
   logic signed [15:0] mulaw  [256];
   logic [7:0]         level  [256];

   rsp_item_type expected_rsp[$];

   assign pending = expected_rsp.size();

   function automatic bit [63:0] fx_mul(bit [63:0] a, bit [63:0] b);
      bit [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
   endfunction

   function automatic bit [63:0] fx_atanh_recip(bit [63:0] q);
      bit [63:0] p, sum, k;
      p = ONE_FX / q;
      sum = 0;
      for (k = 0; p != 0; k++) begin
         sum += p / (2 * k + 1);
         p /= q * q;
      end
      return sum;
   endfunction

   function automatic bit [63:0] fx_exp(bit [63:0] x);
      bit [63:0] sum, term, n;
      sum = ONE_FX;
      term = ONE_FX;
      for (n = 1; n < 80; n++) begin
         term = fx_mul(term, x) / n;
         if (term == 0) break;
         sum += term;
      end
      return sum;
   endfunction

   task automatic build_tables();
      bit [63:0] ln9, ln10, step9, step10, f, lv;
      int        mag;
      int        i;
      ln9 = 4 * fx_atanh_recip(2);
      ln10 = 6 * fx_atanh_recip(3) + 2 * fx_atanh_recip(9);
      step9 = ln9 / 127;
      step10 = ln10 >> 8;
      for (i = 0; i < 256; i++) begin
         if ((i & 127) == 0) begin
            mag = 0;
         end else if ((i & 127) == 127) begin
            mag = 25000;
         end else begin
            f = fx_exp(step9 * (i & 127)) - ONE_FX;
            mag = int'(((f >> 20) * 3125) >> 40);
         end
         mulaw[i] = (i & 128) ? 16'(-mag) : 16'(mag);
      end
      level[255] = 8'd255;
      for (i = 1; i < 256; i++) begin
         lv = fx_exp(step10 * (256 - i));
         level[255 - i] = 8'((((lv >> 20) * 255) / 10) >> 40);
      end
   endtask

   task automatic clear_state();
      int v;
      for (v = 0; v < 32; v++) begin
         vol[v] = 0; pitch[v] = 0; bank[v] = 0; vstart[v] = 0; vend[v] = 0;
         flags[v] = 0; pos[v] = 0; vstop[v] = 0; vloop[v] = 0; frac[v] = 0;
         noise[v] = 0;
      end
      lfsr = NOISE_SEED;
      scale = SCALE_RESET;
      expected_rsp.delete();
   endtask

   function automatic bit noise_step();
      if (lfsr[16]) lfsr = ((lfsr ^ 32'h40) << 1) | 32'd1;
      else lfsr = lfsr << 1;
      return lfsr[0];
   endfunction

   task automatic start_voice(int v, logic [15:0] val);
      logic [31:0] b;
      b = {bank[v], 16'h0};
      flags[v] = {flags[v][FLAG_FIXED], 16'h0} | {1'b0, val};
      if (!val[FLAG_ACTIVE]) return;
      pos[v] = b + vstart[v];
      vstop[v] = b + vend[v];
      if (!flags[v][FLAG_FIXED]) begin
         flags[v][FLAG_FIXED] = 1'b1;
         if (val[FLAG_REVERSE]) begin
            if (pos[v] < vstop[v]) begin
               if (vstop[v] >= 32'h10000) vstop[v] -= 32'h10000;
               if (vloop[v] >= 32'h10000) vloop[v] -= 32'h10000;
            end
            vloop[v] += b;
            if (flags[v][FLAG_LONG]) flags[v][FLAG_LOOP] = 1'b0;
         end else begin
            if (pos[v] > vstop[v]) begin
               vstop[v] += 32'h10000;
               vloop[v] += 32'h10000;
            end
            vloop[v] += b;
            if (vloop[v] > vstop[v] || flags[v][FLAG_LONG]) flags[v][FLAG_LOOP] = 1'b0;
         end
      end
      frac[v] = 0;
   endtask

   task automatic write_voice(logic [15:0] addr, logic [15:0] val);
      int v;
      v = addr[15:4];
      if (v >= 32) return;
      case (addr[3:0])
         OFS_VOL1:  vol[v][15:0] = val;
         OFS_VOL2:  vol[v][31:16] = val;
         OFS_PITCH: pitch[v] = val;
         OFS_FLAGS: start_voice(v, val);
         OFS_BANK:  bank[v] = val[7:0];
         OFS_START: begin flags[v][FLAG_FIXED] = 1'b0; vstart[v] = val; end
         OFS_END:   begin flags[v][FLAG_FIXED] = 1'b0; vend[v] = val; end
         OFS_LOOP:  begin flags[v][FLAG_FIXED] = 1'b0; vloop[v] = {16'h0, val}; end
         default: ;
      endcase
   endtask

   function automatic rsp_item_type mix_frame();
      rsp_item_type r;
      int           acc [4];
      int           s, t, k, v;
      logic [31:0]  off, cnt, p;
      logic [15:0]  n;
      logic [7:0]   b;
      logic signed [15:0] neg;
      for (k = 0; k < 4; k++) acc[k] = 0;
      for (v = 0; v < 32; v++) begin
         if (!flags[v][FLAG_ACTIVE]) continue;
         off = frac[v] + (({16'h0, pitch[v]} * {16'h0, scale}) >> 8);
         cnt = (off >> 16) & 32'h7fff;
         if (cnt != 0) off &= 32'hffff;
         p = pos[v];
         if (flags[v][FLAG_REVERSE]) begin
            p -= cnt;
            if (p <= vloop[v]) begin
               if (flags[v][FLAG_LOOP]) p = vstop[v];
               else begin flags[v][FLAG_ACTIVE] = 1'b0; continue; end
            end
         end else begin
            p += cnt;
            if (p >= vstop[v]) begin
               if (flags[v][FLAG_LOOP]) p = vloop[v];
               else begin flags[v][FLAG_ACTIVE] = 1'b0; continue; end
            end
         end
         p &= 32'hffff;
         b = rom[p[15:0]];
         if (flags[v][FLAG_MULAW]) s = mulaw[b];
         else s = int'($signed(b)) * 256;
         if (flags[v][FLAG_PHASE]) begin
            neg = -s[15:0];
            s = neg;
         end
         if (flags[v][FLAG_NOISE]) begin
            n = {noise[v][14:0], noise_step()};
            t = int'({17'd0, n[14:0]}) - 32'h4000;
            noise[v] = n;
            if (t > 255) t = 255;
            else if (t < 0) t = 0;
            s = mulaw[t];
         end
         for (k = 0; k < 4; k++)
            acc[k] += (s * int'({24'd0, level[vol[v][8*k +: 8]]})) >>> 8;
         frac[v] = off;
         pos[v] = p;
      end
      r = '0;
      r.result_kind = KIND_FRAME;
      r.out_left1  = 16'(acc[0] >>> 3);
      r.out_right1 = 16'(acc[1] >>> 3);
      r.out_left2  = 16'(acc[2] >>> 3);
      r.out_right2 = 16'(acc[3] >>> 3);
      return r;
   endfunction

   task automatic predict(req_item_type it);
      rsp_item_type r;
      int           v;
      case (it.mode)
         CMD_WRITE: write_voice(it.reg_addr, it.write_data);
         CMD_LOAD:  rom[it.rom_addr] = it.rom_byte;
         CMD_READ: begin
            v = it.reg_addr[15:4];
            r = '0;
            r.result_kind = KIND_READ;
            r.read_data = (v < 32) ? flags[v][15:0] : 16'h0;
            expected_rsp.push_back(r);
         end
         default: expected_rsp.push_back(mix_frame());
      endcase
   endtask

   task automatic compare(rsp_item_type got);
      rsp_item_type want;
      if (expected_rsp.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %h", got);
         return;
      end
      want = expected_rsp.pop_front();
      if (got.result_kind !== want.result_kind || got.read_data !== want.read_data ||
          got.out_left1 !== want.out_left1 || got.out_right1 !== want.out_right1 ||
          got.out_left2 !== want.out_left2 || got.out_right2 !== want.out_right2) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected kind %0d rd %h %0d %0d %0d %0d, got kind %0d rd %h %0d %0d %0d %0d",
                     want.result_kind, want.read_data, want.out_left1, want.out_right1,
                     want.out_left2, want.out_right2, got.result_kind, got.read_data,
                     got.out_left1, got.out_right1, got.out_left2, got.out_right2);
      end
   endtask

   initial begin
      mismatches = 0;
      build_tables();
      clear_state();
   end

   always @(negedge clock) begin
      if (reset) begin
         clear_state();
      end else begin
         if (csr_we) scale = csr_wdata;
         if (pop && !empty) compare(rsp_item);
         if (push && !full) predict(req_item);
      end
   end

endmodule

// ===== verif/tb_pcm_voice_mixer_32ch.sv =====
// Testbench top for the PCM voice mixer: drives items and pitch_scale, gives the verdict.
`timescale 1ns / 1ps
module tb_pcm_voice_mixer_32ch;
   import pvm_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         push = 1'b0;
   logic         pop = 1'b0;
   logic         csr_we = 1'b0;
   logic [15:0]  csr_wdata = '0;
   req_item_type req_item = '0;
   logic         full, empty;
   rsp_item_type rsp_item;
   int           mismatches, pending;
   int           cycles = 0;
   int           sent;
   bit           calm = 1'b0;

   always #1 clock = ~clock;

   pcm_voice_mixer_32ch dut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_item(req_item),
      .empty(empty), .pop(pop), .rsp_item(rsp_item), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   pvm_mix_checker chk (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_item(req_item),
      .empty(empty), .pop(pop), .rsp_item(rsp_item), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .mismatches(mismatches), .pending(pending)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      pop <= calm || ($urandom_range(99) >= 12);
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic req_item_type item_of(logic [1:0] mode, logic [15:0] addr,
                                            logic [15:0] data);
      req_item_type it;
      it.mode = mode;
      it.reg_addr = addr;
      it.write_data = data;
      it.rom_addr = 16'($urandom);
      it.rom_byte = 8'($urandom);
      return it;
   endfunction

   function automatic req_item_type load_of(logic [15:0] a, logic [7:0] b);
      req_item_type it;
      it = item_of(CMD_LOAD, 16'($urandom), 16'($urandom));
      it.rom_addr = a;
      it.rom_byte = b;
      return it;
   endfunction

   task automatic send(req_item_type it);
      bit taken;
      if (!calm) begin
         while ($urandom_range(99) < 12) begin
            push <= 1'b0;
            @(posedge clock);
         end
      end
      push <= 1'b1;
      req_item <= it;
      do begin
         @(negedge clock);
         taken = !full;
         @(posedge clock);
      end while (!taken);
      sent++;
   endtask

   task automatic set_scale(logic [15:0] value);
      push <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wr(logic [11:0] v, logic [3:0] ofs, logic [15:0] data);
      send(item_of(CMD_WRITE, {v, ofs}, data));
   endtask

   task automatic program_voice();
      logic [11:0] v;
      logic [15:0] fl;
      int          i;
      v = ($urandom_range(7) == 0) ? 12'($urandom) : 12'($urandom_range(31));
      wr(v, OFS_VOL1, 16'($urandom));
      wr(v, OFS_VOL2, 16'($urandom));
      wr(v, OFS_PITCH, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1023)));
      wr(v, OFS_BANK, 16'($urandom));
      wr(v, OFS_START, 16'($urandom));
      wr(v, OFS_END, 16'($urandom));
      wr(v, OFS_LOOP, 16'($urandom));
      fl = 16'($urandom);
      fl[FLAG_ACTIVE] = ($urandom_range(99) < 85);
      wr(v, OFS_FLAGS, fl);
      if ($urandom_range(3) == 0) wr(v, OFS_FLAGS, fl ^ 16'($urandom_range(255)));
      for (i = $urandom_range(6, 1); i > 0; i--) send(item_of(CMD_TICK, 16'($urandom),
                                                               16'($urandom)));
      send(item_of(CMD_READ, {v, 4'($urandom)}, 16'($urandom)));
   endtask

   task automatic run_random(int n);
      int r;
      logic [15:0] a;
      sent = 0;
      while (sent < n) begin
         r = $urandom_range(99);
         if (r < 35) begin
            program_voice();
         end else if (r < 70) begin
            send(item_of(CMD_TICK, 16'($urandom), 16'($urandom)));
         end else if (r < 82) begin
            a = 16'($urandom);
            if ($urandom_range(9) != 0) a[15:9] = 0;
            send(item_of(CMD_READ, a, 16'($urandom)));
         end else if (r < 90) begin
            send(load_of(16'($urandom), 8'($urandom)));
         end else begin
            send(item_of(2'($urandom), 16'($urandom), 16'($urandom)));
         end
      end
   endtask

   initial begin
      int a;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (a = 0; a < 65536; a++) send(load_of(16'(a), 8'($urandom)));
      set_scale(16'd256);

      send(item_of(CMD_READ, 16'h0006, 16'hffff));
      send(item_of(CMD_READ, 16'h01f6, 16'h0000));
      wr(12'd32, OFS_FLAGS, 16'hffff);
      send(item_of(CMD_READ, 16'h0206, 16'h0000));
      send(item_of(CMD_READ, 16'hffff, 16'hffff));
      wr(12'd0, 4'h1, 16'hffff);
      send(load_of(16'h0010, 8'h80));
      send(load_of(16'h0011, 8'h7f));
      send(load_of(16'h0012, 8'h80));
      wr(12'd0, OFS_VOL1, 16'hffff);
      wr(12'd0, OFS_VOL2, 16'h00ff);
      wr(12'd0, OFS_PITCH, 16'hffff);
      wr(12'd0, OFS_START, 16'h0010);
      wr(12'd0, OFS_END, 16'h0013);
      wr(12'd0, OFS_LOOP, 16'h0010);
      wr(12'd0, OFS_FLAGS, 16'h4082);
      wr(12'd1, OFS_VOL1, 16'hffff);
      wr(12'd1, OFS_END, 16'h0004);
      wr(12'd1, OFS_FLAGS, 16'h4090);
      wr(12'd31, OFS_PITCH, 16'hffff);
      wr(12'd31, OFS_END, 16'h0001);
      wr(12'd31, OFS_FLAGS, 16'h4008);
      repeat (3) send(item_of(CMD_TICK, 16'h0000, 16'h0000));
      send(item_of(CMD_READ, 16'h01f6, 16'h0000));

      run_random(130);
      set_scale(16'd0);
      run_random(130);
      set_scale(16'hffff);
      calm = 1'b1;
      run_random(130);
      calm = 1'b0;
      set_scale(16'($urandom_range(65534, 1)));
      run_random(130);
      set_scale(16'd512);
      run_random(130);

      push <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/pvm_pkg.sv
design/pvm_ram.sv
design/pvm_front.sv
design/pvm_back.sv
design/pcm_voice_mixer_32ch.sv
verif/pvm_mix_checker.sv
verif/tb_pcm_voice_mixer_32ch.sv
